// ----- hdl/bae_pkg.sv -----
// shared types, constants, polymod step, charset and microcode table of the address encoder
package bae_pkg;

	localparam int PFX_DEPTH = 83;
	localparam int PFX_AW = $clog2(PFX_DEPTH);
	localparam int MAX_ADDRESS_CHARS = 90;
	localparam int MAX_DATA_BYTES = 40;
	localparam int CHK_DIGITS = 6;
	localparam int STEP_W = 5;

	localparam logic [29:0] GEN [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};
	localparam logic [29:0] FIN_BECH32 = 30'h00000001;
	localparam logic [29:0] FIN_BECH32M = 30'h2bc830a3;
	localparam logic [6:0] SEP_CHAR = 7'h31;
	localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	typedef enum logic [1:0] {
		CMD_BEGIN,
		CMD_PREFIX,
		CMD_DATA,
		CMD_END
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [7:0] value;
	} op_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic last;
		logic error;
	} sym_t;

	// output source
	typedef enum logic [2:0] {
		EM_NONE,
		EM_ERR,
		EM_VAL,
		EM_SEP,
		EM_DIGIT,
		EM_CHK
	} emit_t;

	// checksum register operation
	typedef enum logic [2:0] {
		CK_HOLD,
		CK_ONE,
		CK_STEP_HI,
		CK_STEP,
		CK_STEP_D,
		CK_FIN,
		CK_SHIFT
	} ck_t;

	// digit source
	typedef enum logic [1:0] {
		DS_RAM,
		DS_VER,
		DS_ACC,
		DS_PAD
	} ds_t;

	typedef enum logic [1:0] {
		PH_KEEP,
		PH_GO_IDLE,
		PH_GO_PREFIX,
		PH_GO_DATA
	} ph_t;

	// jump conditions
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_GOTO,
		JC_DISPATCH,
		JC_MORE_PFX,
		JC_TWO,
		JC_NO_PAD,
		JC_CNT_MORE
	} jc_t;

	typedef struct packed {
		logic wait_in;
		emit_t emit;
		logic last;
		ck_t ck;
		ds_t ds;
		ph_t ph;
		logic begin_ld;
		logic pfx_wr;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic nb_ld;
		logic nb_sub;
		logic data_done;
		logic cnt_ld;
		logic cnt_dec;
		jc_t jc;
		logic [STEP_W-1:0] tgt;
	} ctrl_t;

	typedef struct packed {
		logic fail;
		cmd_t cmd;
		logic in_prefix;
		logic more_pfx;
		logic two_digits;
		logic no_pad;
		logic cnt_more;
	} stat_t;

	// microcode addresses
	localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
	localparam logic [STEP_W-1:0] ST_DISP  = 5'd1;
	localparam logic [STEP_W-1:0] ST_ERR   = 5'd2;
	localparam logic [STEP_W-1:0] ST_BEGIN = 5'd3;
	localparam logic [STEP_W-1:0] ST_PFX   = 5'd4;
	localparam logic [STEP_W-1:0] ST_R0    = 5'd5;
	localparam logic [STEP_W-1:0] ST_R1    = 5'd6;
	localparam logic [STEP_W-1:0] ST_R2    = 5'd7;
	localparam logic [STEP_W-1:0] ST_R3    = 5'd8;
	localparam logic [STEP_W-1:0] ST_D0    = 5'd9;
	localparam logic [STEP_W-1:0] ST_D1    = 5'd10;
	localparam logic [STEP_W-1:0] ST_D2    = 5'd11;
	localparam logic [STEP_W-1:0] ST_E0    = 5'd12;
	localparam logic [STEP_W-1:0] ST_E1    = 5'd13;
	localparam logic [STEP_W-1:0] ST_E2    = 5'd14;
	localparam logic [STEP_W-1:0] ST_E3    = 5'd15;
	localparam logic [STEP_W-1:0] ST_E4    = 5'd16;
	localparam logic [STEP_W-1:0] ST_E5    = 5'd17;
	localparam logic [STEP_W-1:0] ST_E6    = 5'd18;

	function automatic logic [29:0] poly_step(input logic [29:0] c);
		logic [29:0] r;
		r = {c[24:0], 5'd0};
		for (int i = 0; i < 5; i++) begin
			if (c[25+i]) begin
				r = r ^ GEN[i];
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] dchar(input logic [4:0] d);
		logic [7:0] b;
		b = CHARSET[8*(31-int'(d)) +: 8];
		return b[6:0];
	endfunction

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] a);
		ctrl_t c;
		c = '0;
		case (a)
			ST_IDLE: begin
				c.wait_in = 1'b1;
			end
			ST_DISP: begin
				c.jc = JC_DISPATCH;
			end
			ST_ERR: begin
				c.emit = EM_ERR;
				c.last = 1'b1;
				c.ph = PH_GO_IDLE;
				c.jc = JC_GOTO;
				c.tgt = ST_IDLE;
			end
			ST_BEGIN: begin
				c.begin_ld = 1'b1;
				c.ck = CK_ONE;
				c.ph = PH_GO_PREFIX;
				c.jc = JC_GOTO;
				c.tgt = ST_IDLE;
			end
			ST_PFX: begin
				c.emit = EM_VAL;
				c.ck = CK_STEP_HI;
				c.pfx_wr = 1'b1;
				c.jc = JC_GOTO;
				c.tgt = ST_IDLE;
			end
			ST_R0: begin
				c.ck = CK_STEP;
				c.idx_clr = 1'b1;
				c.rd_en = 1'b1;
			end
			ST_R1: begin
				c.ck = CK_STEP_D;
				c.ds = DS_RAM;
				c.idx_inc = 1'b1;
				c.rd_en = 1'b1;
				c.jc = JC_MORE_PFX;
				c.tgt = ST_R1;
			end
			ST_R2: begin
				c.emit = EM_SEP;
			end
			ST_R3: begin
				c.emit = EM_DIGIT;
				c.ds = DS_VER;
				c.ck = CK_STEP_D;
				c.ph = PH_GO_DATA;
			end
			ST_D0: begin
				c.nb_ld = 1'b1;
			end
			ST_D1: begin
				c.emit = EM_DIGIT;
				c.ds = DS_ACC;
				c.ck = CK_STEP_D;
				c.nb_sub = 1'b1;
				c.jc = JC_TWO;
				c.tgt = ST_D1;
			end
			ST_D2: begin
				c.data_done = 1'b1;
				c.jc = JC_GOTO;
				c.tgt = ST_IDLE;
			end
			ST_E0: begin
				c.jc = JC_NO_PAD;
				c.tgt = ST_E2;
			end
			ST_E1: begin
				c.emit = EM_DIGIT;
				c.ds = DS_PAD;
				c.ck = CK_STEP_D;
			end
			ST_E2: begin
				c.ck = CK_STEP;
				c.cnt_ld = 1'b1;
			end
			ST_E3: begin
				c.ck = CK_STEP;
				c.cnt_dec = 1'b1;
				c.jc = JC_CNT_MORE;
				c.tgt = ST_E3;
			end
			ST_E4: begin
				c.ck = CK_FIN;
				c.cnt_ld = 1'b1;
			end
			ST_E5: begin
				c.emit = EM_CHK;
				c.ck = CK_SHIFT;
				c.cnt_dec = 1'b1;
				c.jc = JC_CNT_MORE;
				c.tgt = ST_E5;
			end
			ST_E6: begin
				c.emit = EM_CHK;
				c.last = 1'b1;
				c.ck = CK_SHIFT;
				c.ph = PH_GO_IDLE;
				c.jc = JC_GOTO;
				c.tgt = ST_IDLE;
			end
			default: begin
				c.jc = JC_GOTO;
				c.tgt = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/bae_ram.sv -----
// generic single-write, single-read ram with registered read data
module bae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bae_useq.sv -----
// microcode sequencer: step counter, control rom lookup and jump logic
module bae_useq (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input bae_pkg::stat_t stat,
	output bae_pkg::ctrl_t ctrl
);

	logic [bae_pkg::STEP_W-1:0] step_q;
	logic [bae_pkg::STEP_W-1:0] step_next;
	logic [bae_pkg::STEP_W-1:0] disp_tgt;
	logic taken;

	assign ctrl = bae_pkg::ucode(step_q);

	// entry point for a freshly accepted item
	always_comb begin
		if (stat.fail) begin
			disp_tgt = bae_pkg::ST_ERR;
		end else begin
			case (stat.cmd)
				bae_pkg::CMD_BEGIN: disp_tgt = bae_pkg::ST_BEGIN;
				bae_pkg::CMD_PREFIX: disp_tgt = bae_pkg::ST_PFX;
				bae_pkg::CMD_DATA: disp_tgt = stat.in_prefix ? bae_pkg::ST_R0 : bae_pkg::ST_D0;
				bae_pkg::CMD_END: disp_tgt = bae_pkg::ST_E0;
				default: disp_tgt = bae_pkg::ST_IDLE;
			endcase
		end
	end

	always_comb begin
		case (ctrl.jc)
			bae_pkg::JC_GOTO: taken = 1'b1;
			bae_pkg::JC_MORE_PFX: taken = stat.more_pfx;
			bae_pkg::JC_TWO: taken = stat.two_digits;
			bae_pkg::JC_NO_PAD: taken = stat.no_pad;
			bae_pkg::JC_CNT_MORE: taken = stat.cnt_more;
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		if (!adv) begin
			step_next = step_q;
		end else if (ctrl.jc == bae_pkg::JC_DISPATCH) begin
			step_next = disp_tgt;
		end else if (taken) begin
			step_next = ctrl.tgt;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bae_pkg::ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

`ifndef SYNTHESIS
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wait_in && adv) |=> (step_q == bae_pkg::ST_DISP))
		else $error("accepted item not followed by dispatch");
`endif

endmodule

// ----- hdl/bech32_address_encoder_top.sv -----
// top level of the streaming bech32 / bech32m address encoder
//
//  channel  valid      stall      payload  direction
//  -------  ---------  ---------  -------  ---------
//  op       op_valid   op_stall   op       in   (cmd, value)
//  sym      sym_valid  sym_stall  sym      out  (out_char, last, error)
//
// one microcode step per cycle unless an absent op or a stalled sym holds it; an item is
// taken only at the idle step. the first data byte also replays the prefix through
// the single polymod step unit and the prefix ram read port. reset clears the step,
// phase, checksum, counts, carry and sym valid; loop counters and the prefix ram
// need no clearing.
// a stalled sym holds the step that wants to emit until the register frees.
module bech32_address_encoder_top (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	output logic op_stall,
	input bae_pkg::op_t op,
	output logic sym_valid,
	input logic sym_stall,
	output bae_pkg::sym_t sym
);

	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_PREFIX,
		PHASE_DATA
	} phase_t;

	localparam logic [7:0] CH_MIN = 8'd33;
	localparam logic [7:0] CH_MAX = 8'd126;
	localparam logic [7:0] UC_MIN = 8'd65;
	localparam logic [7:0] UC_MAX = 8'd90;
	localparam logic [7:0] VER_MAX = 8'd16;
	localparam logic [10:0] RECIP5 = 11'd1639;

	bae_pkg::ctrl_t ctrl;
	bae_pkg::stat_t stat;
	logic adv;
	logic emit_load;

	phase_t phase_q;
	logic [29:0] chk_q;
	logic [4:0] ver_q;
	logic [6:0] pcnt_q;
	logic [5:0] bcnt_q;
	logic [3:0] carry_q;
	logic [2:0] cbits_q;

	bae_pkg::cmd_t cmd_q;
	logic [7:0] val_q;
	logic [6:0] idx_q;
	logic [3:0] nb_q;
	logic [2:0] cnt_q;
	bae_pkg::sym_t sym_q;
	logic sym_valid_q;

	logic ram_we;
	logic ram_re;
	logic [bae_pkg::PFX_AW-1:0] ram_raddr;
	logic [6:0] ram_rdata;

	logic bad_char;
	logic [6:0] n_bytes;
	logic [9:0] bits_up;
	logic [20:0] prod;
	logic [7:0] total;
	logic fail;

	logic [11:0] acc;
	logic [11:0] acc_sh;
	logic [3:0] sh;
	logic [8:0] pad_w;
	logic [4:0] digit;
	logic [3:0] carry_next;
	logic [29:0] poly;
	logic [29:0] fin;
	logic [29:0] chk_next;
	bae_pkg::sym_t sym_next;

	bae_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.stat(stat),
		.ctrl(ctrl)
	);

	bae_ram #(
		.WIDTH(7),
		.DEPTH(bae_pkg::PFX_DEPTH)
	) u_pfx_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(pcnt_q),
		.wdata(val_q[6:0]),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign op_stall = !ctrl.wait_in;
	assign adv = !(ctrl.wait_in && !op_valid)
		&& !((ctrl.emit != bae_pkg::EM_NONE) && sym_valid_q && sym_stall);
	assign emit_load = adv && (ctrl.emit != bae_pkg::EM_NONE);

	assign ram_we = adv && ctrl.pfx_wr;
	assign ram_raddr = ctrl.idx_clr ? '0 : idx_q;
	assign ram_re = adv && ctrl.rd_en && (ram_raddr < pcnt_q);

	// finished length check: ceil(8n/5) digits via reciprocal multiply
	assign bad_char = (val_q < CH_MIN) || (val_q > CH_MAX)
		|| ((val_q >= UC_MIN) && (val_q <= UC_MAX));
	assign n_bytes = {1'b0, bcnt_q} + 7'd1;
	assign bits_up = {n_bytes, 3'd0} + 10'd4;
	assign prod = {11'd0, bits_up} * {10'd0, RECIP5};
	assign total = {1'b0, pcnt_q} + prod[20:13] + 8'(bae_pkg::CHK_DIGITS + 2);

	always_comb begin
		case (cmd_q)
			bae_pkg::CMD_BEGIN: fail = val_q > VER_MAX;
			bae_pkg::CMD_PREFIX: fail = (phase_q != PHASE_PREFIX) || bad_char
				|| (pcnt_q >= 7'(bae_pkg::PFX_DEPTH));
			bae_pkg::CMD_DATA: fail = (phase_q == PHASE_IDLE) || (pcnt_q == '0)
				|| (n_bytes > 7'(bae_pkg::MAX_DATA_BYTES))
				|| (total > 8'(bae_pkg::MAX_ADDRESS_CHARS));
			bae_pkg::CMD_END: fail = (phase_q != PHASE_DATA) || (pcnt_q == '0)
				|| (bcnt_q < 6'd2);
			default: fail = 1'b1;
		endcase
	end

	always_comb begin
		stat.fail = fail;
		stat.cmd = cmd_q;
		stat.in_prefix = phase_q == PHASE_PREFIX;
		stat.more_pfx = idx_q < pcnt_q;
		stat.two_digits = nb_q >= 4'd10;
		stat.no_pad = cbits_q == '0;
		stat.cnt_more = cnt_q != 3'd1;
	end

	// 5-bit regrouping of carry bits and the new byte
	assign acc = {carry_q, val_q};
	assign sh = nb_q - 4'd5;
	assign acc_sh = acc >> sh;
	assign pad_w = {5'd0, carry_q} << (3'd5 - cbits_q);
	assign carry_next = acc[3:0] & ~(4'hf << nb_q);

	always_comb begin
		case (ctrl.ds)
			bae_pkg::DS_RAM: digit = ram_rdata[4:0];
			bae_pkg::DS_VER: digit = ver_q;
			bae_pkg::DS_ACC: digit = acc_sh[4:0];
			bae_pkg::DS_PAD: digit = pad_w[4:0];
			default: digit = '0;
		endcase
	end

	assign poly = bae_pkg::poly_step(chk_q);
	assign fin = (ver_q == '0) ? bae_pkg::FIN_BECH32 : bae_pkg::FIN_BECH32M;

	always_comb begin
		case (ctrl.ck)
			bae_pkg::CK_ONE: chk_next = 30'd1;
			bae_pkg::CK_STEP_HI: chk_next = poly ^ {27'd0, val_q[7:5]};
			bae_pkg::CK_STEP: chk_next = poly;
			bae_pkg::CK_STEP_D: chk_next = poly ^ {25'd0, digit};
			bae_pkg::CK_FIN: chk_next = chk_q ^ fin;
			bae_pkg::CK_SHIFT: chk_next = {chk_q[24:0], 5'd0};
			default: chk_next = chk_q;
		endcase
	end

	always_comb begin
		sym_next.last = ctrl.last;
		sym_next.error = 1'b0;
		case (ctrl.emit)
			bae_pkg::EM_ERR: begin
				sym_next.out_char = '0;
				sym_next.error = 1'b1;
			end
			bae_pkg::EM_VAL: sym_next.out_char = val_q[6:0];
			bae_pkg::EM_SEP: sym_next.out_char = bae_pkg::SEP_CHAR;
			bae_pkg::EM_DIGIT: sym_next.out_char = bae_pkg::dchar(digit);
			bae_pkg::EM_CHK: sym_next.out_char = bae_pkg::dchar(chk_q[29:25]);
			default: sym_next.out_char = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			chk_q <= 30'd1;
			ver_q <= '0;
			pcnt_q <= '0;
			bcnt_q <= '0;
			carry_q <= '0;
			cbits_q <= '0;
			sym_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				sym_valid_q <= 1'b1;
			end else if (!sym_stall) begin
				sym_valid_q <= 1'b0;
			end
			if (adv) begin
				chk_q <= chk_next;
				case (ctrl.ph)
					bae_pkg::PH_GO_IDLE: phase_q <= PHASE_IDLE;
					bae_pkg::PH_GO_PREFIX: phase_q <= PHASE_PREFIX;
					bae_pkg::PH_GO_DATA: phase_q <= PHASE_DATA;
					default: phase_q <= phase_q;
				endcase
				if (ctrl.begin_ld) begin
					ver_q <= val_q[4:0];
					pcnt_q <= '0;
					bcnt_q <= '0;
					carry_q <= '0;
					cbits_q <= '0;
				end
				if (ctrl.pfx_wr) begin
					pcnt_q <= pcnt_q + 7'd1;
				end
				if (ctrl.data_done) begin
					carry_q <= carry_next;
					cbits_q <= nb_q[2:0];
					bcnt_q <= bcnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			cmd_q <= op.cmd;
			val_q <= op.value;
		end
		if (emit_load) begin
			sym_q <= sym_next;
		end
		if (adv) begin
			if (ctrl.idx_clr) begin
				idx_q <= 7'd1;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx_q + 7'd1;
			end
			if (ctrl.nb_ld) begin
				nb_q <= {1'b0, cbits_q} + 4'd8;
			end else if (ctrl.nb_sub) begin
				nb_q <= nb_q - 4'd5;
			end
			if (ctrl.cnt_ld) begin
				cnt_q <= 3'(bae_pkg::CHK_DIGITS - 1);
			end else if (ctrl.cnt_dec) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	assign sym_valid = sym_valid_q;
	assign sym = sym_q;

`ifndef SYNTHESIS
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && sym.error) |-> (sym.last && (sym.out_char == '0)))
		else $error("error item without last or with a character");

	a_pcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= 7'(bae_pkg::PFX_DEPTH))
		else $error("prefix count beyond store depth");

	a_ram_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (ram_raddr < pcnt_q))
		else $error("prefix replay reads an unwritten entry");

	a_carry_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctrl.data_done) |-> (nb_q < 4'd5))
		else $error("leftover bits not below one digit");
`endif

endmodule
